// ----- rtl/core/wlsv_pkg.sv -----
`default_nettype none

package wlsv_pkg;

   localparam int WINDOW      = 16;
   localparam int MIN_SAMPLES = 4;
   localparam int NUM_AXES    = 3;

   localparam int LOG_W = $clog2(WINDOW);
   localparam int N_W   = $clog2(WINDOW + 1);

   localparam int DT_W  = 32;
   localparam int POS_W = 32;
   localparam int VEL_W = 48;
   localparam int FRAC  = 16;

   localparam int SX_W  = DT_W + LOG_W;
   localparam int SXX_W = 2 * DT_W + LOG_W;
   localparam int SY_W  = POS_W + LOG_W;
   localparam int SXY_W = DT_W + POS_W + LOG_W;
   localparam int ACC_W = DT_W + POS_W + 2 * LOG_W + 2;

   localparam int QUO_W = VEL_W;
   localparam int HI_SH = QUO_W - FRAC;
   localparam int R_W   = ACC_W + 1;
   localparam int SEQ_W = $clog2((SX_W > QUO_W) ? SX_W : QUO_W);

   localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
   localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

   typedef struct packed {
      logic [DT_W-1:0]                 stamp;
      logic [NUM_AXES-1:0][POS_W-1:0] pos;
   } sample_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_DRAIN,
      ST_SOLVE,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      SP_IDLE,
      SP_MUL,
      SP_PREP,
      SP_DIV,
      SP_FIN
   } solve_phase_type;

   typedef enum logic [1:0] {
      FIT_OK         = 2'd0,
      FIT_FEW        = 2'd1,
      FIT_DEGENERATE = 2'd2
   } fit_status_type;

   typedef struct packed {
      logic done;
      logic den_zero;
   } solve_status_type;

endpackage

`default_nettype wire

// ----- rtl/core/wlsv_req_if.sv -----
`default_nettype none

interface wlsv_req_if;
   import wlsv_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [DT_W-1:0]         sample_time;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [POS_W-1:0] pos_z;

   modport source (output valid, sample_time, pos_x, pos_y, pos_z, input ready);
   modport sink (input valid, sample_time, pos_x, pos_y, pos_z, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wlsv_rsp_if.sv -----
`default_nettype none

interface wlsv_rsp_if;
   import wlsv_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [VEL_W-1:0] vel_x;
   logic signed [VEL_W-1:0] vel_y;
   logic signed [VEL_W-1:0] vel_z;
   logic [1:0]              fit_status;
   logic                    x_held;

   modport source (output valid, vel_x, vel_y, vel_z, fit_status, x_held, input ready);
   modport sink (input valid, vel_x, vel_y, vel_z, fit_status, x_held, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wlsv_cell.sv -----
`default_nettype none

module wlsv_cell (
   input  wire logic                 clock,
   input  wire logic                 shift,
   input  wire wlsv_pkg::sample_type d,
   output wlsv_pkg::sample_type      q
);
   import wlsv_pkg::*;

   sample_type q_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         q_ff <= d;
      end
   end

   assign q = q_ff;
endmodule

`default_nettype wire

// ----- rtl/core/wlsv_solve.sv -----
`default_nettype none

module wlsv_solve (
   input  wire logic                                               clock,
   input  wire logic                                               reset,
   input  wire logic                                               start,
   input  wire logic [wlsv_pkg::N_W-1:0]                           win_count,
   input  wire logic [wlsv_pkg::SX_W-1:0]                          sum_t,
   input  wire logic [wlsv_pkg::SXX_W-1:0]                         sum_tt,
   input  wire logic [wlsv_pkg::NUM_AXES-1:0][wlsv_pkg::SY_W-1:0]  sum_p,
   input  wire logic [wlsv_pkg::NUM_AXES-1:0][wlsv_pkg::SXY_W-1:0] sum_tp,
   output wlsv_pkg::solve_status_type                              status,
   output logic [wlsv_pkg::NUM_AXES-1:0][wlsv_pkg::VEL_W-1:0]      vel
);
   import wlsv_pkg::*;

   solve_phase_type phase_ff, phase_in;
   logic [SEQ_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic             den_zero_ff;

   logic [ACC_W-1:0] mc_t_ff, mc_tt_ff, den_ff;
   logic [SX_W-1:0]  mp_t_ff;
   logic [N_W-1:0]   mp_n_ff;
   logic [NUM_AXES-1:0][ACC_W-1:0] mc_p_ff, mc_tp_ff, num_ff;
   logic [NUM_AXES-1:0][R_W-1:0]   rem_ff;
   logic [NUM_AXES-1:0][QUO_W-1:0] low_ff, quo_ff;
   logic [NUM_AXES-1:0]            neg_ff, sat_ff;
   logic [NUM_AXES-1:0][VEL_W-1:0] vel_ff;

   logic [NUM_AXES-1:0][ACC_W-1:0] mag;
   logic [NUM_AXES-1:0][R_W-1:0]   trial;
   logic [NUM_AXES-1:0]            fits;
   logic [NUM_AXES-1:0][VEL_W-1:0] fmt;

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         mag[a]   = num_ff[a][ACC_W-1] ? (-num_ff[a]) : num_ff[a];
         trial[a] = {rem_ff[a][R_W-2:0], low_ff[a][QUO_W-1]};
         fits[a]  = trial[a] >= R_W'(den_ff);
         if (neg_ff[a]) begin
            fmt[a] = (sat_ff[a] || (quo_ff[a][QUO_W-1] && (|quo_ff[a][QUO_W-2:0])))
                     ? VEL_MIN : (-quo_ff[a]);
         end else begin
            fmt[a] = (sat_ff[a] || quo_ff[a][QUO_W-1]) ? VEL_MAX : quo_ff[a];
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         SP_IDLE: begin
            if (start) begin
               phase_in = SP_MUL;
               cnt_in   = '0;
            end
         end
         SP_MUL: begin
            if (cnt_ff == SEQ_W'(SX_W - 1)) begin
               phase_in = SP_PREP;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         SP_PREP: begin
            if (den_ff == '0) begin
               phase_in = SP_IDLE;
               done_in  = 1'b1;
            end else begin
               phase_in = SP_DIV;
            end
         end
         SP_DIV: begin
            if (cnt_ff == SEQ_W'(QUO_W - 1)) begin
               phase_in = SP_FIN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         SP_FIN: begin
            phase_in = SP_IDLE;
            done_in  = 1'b1;
         end
         default: begin
            phase_in = SP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= SP_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (phase_ff)
         SP_IDLE: begin
            if (start) begin
               mc_t_ff  <= ACC_W'(sum_t);
               mc_tt_ff <= ACC_W'(sum_tt);
               mp_t_ff  <= sum_t;
               mp_n_ff  <= win_count;
               den_ff   <= '0;
               for (int a = 0; a < NUM_AXES; a++) begin
                  mc_p_ff[a]  <= ACC_W'($signed(sum_p[a]));
                  mc_tp_ff[a] <= ACC_W'($signed(sum_tp[a]));
                  num_ff[a]   <= '0;
               end
            end
         end
         SP_MUL: begin
            den_ff <= den_ff + (mp_n_ff[0] ? mc_tt_ff : '0) - (mp_t_ff[0] ? mc_t_ff : '0);
            for (int a = 0; a < NUM_AXES; a++) begin
               num_ff[a]   <= num_ff[a] + (mp_n_ff[0] ? mc_tp_ff[a] : '0)
                              - (mp_t_ff[0] ? mc_p_ff[a] : '0);
               mc_p_ff[a]  <= mc_p_ff[a] << 1;
               mc_tp_ff[a] <= mc_tp_ff[a] << 1;
            end
            mc_t_ff  <= mc_t_ff << 1;
            mc_tt_ff <= mc_tt_ff << 1;
            mp_t_ff  <= mp_t_ff >> 1;
            mp_n_ff  <= mp_n_ff >> 1;
         end
         SP_PREP: begin
            den_zero_ff <= (den_ff == '0);
            for (int a = 0; a < NUM_AXES; a++) begin
               neg_ff[a] <= num_ff[a][ACC_W-1];
               rem_ff[a] <= R_W'(mag[a][ACC_W-1:HI_SH]);
               sat_ff[a] <= ACC_W'(mag[a][ACC_W-1:HI_SH]) >= den_ff;
               low_ff[a] <= {mag[a][HI_SH-1:0], {FRAC{1'b0}}};
               quo_ff[a] <= '0;
            end
         end
         SP_DIV: begin
            for (int a = 0; a < NUM_AXES; a++) begin
               rem_ff[a] <= fits[a] ? (trial[a] - R_W'(den_ff)) : trial[a];
               quo_ff[a] <= {quo_ff[a][QUO_W-2:0], fits[a]};
               low_ff[a] <= low_ff[a] << 1;
            end
         end
         SP_FIN: begin
            vel_ff <= fmt;
         end
         default: begin
         end
      endcase
   end

   assign status = '{done: done_ff, den_zero: den_zero_ff};
   assign vel    = vel_ff;
endmodule

`default_nettype wire

// ----- rtl/core/window_least_squares_velocity.sv -----
`default_nettype none

// Channel   Direction  Payload
// req_ch    in         sample_time, pos_x, pos_y, pos_z
// rsp_ch    out        vel_x, vel_y, vel_z, fit_status, x_held
//
// A request with fewer than four samples in the window, the new one included, goes straight to the output
// state. Otherwise a request makes one turn of the sample ring through the sum pipeline, then
// a bit-serial pass for the cross products and a 48-step division.
// Synchronous reset empties the window and clears the velocity memory.
// A new request is taken only when the previous one has been placed in the output register.

module window_least_squares_velocity (
   input wire logic  clock,
   input wire logic  reset,
   wlsv_req_if.sink  req_ch,
   wlsv_rsp_if.source rsp_ch
);
   import wlsv_pkg::*;

   state_type      state_ff, state_in;
   logic [LOG_W-1:0] cyc_ff, cyc_in;
   logic [N_W-1:0] count_ff, count_in;
   logic           few_ff;
   logic           accepted, shift_en, sol_start, load_rsp;

   sample_type cell_q [WINDOW];
   sample_type ring_d;
   sample_type tap;

   logic [N_W:0]    tap_pos;
   logic            tap_valid, tap_first;
   logic [DT_W-1:0] t0_ff, dt;

   logic                           s1_valid_ff, s2_valid_ff;
   logic [DT_W-1:0]                s1_dt_ff, s2_dt_ff;
   logic [NUM_AXES-1:0][POS_W-1:0] s1_pos_ff, s2_pos_ff;
   logic [2*DT_W-1:0]              s2_tt_ff;
   logic [NUM_AXES-1:0][DT_W+POS_W-1:0] s2_tp_ff;
   logic signed [DT_W+POS_W:0]     tp_full [NUM_AXES];

   logic [SX_W-1:0]  sum_t_ff;
   logic [SXX_W-1:0] sum_tt_ff;
   logic [NUM_AXES-1:0][SY_W-1:0]  sum_p_ff;
   logic [NUM_AXES-1:0][SXY_W-1:0] sum_tp_ff;

   solve_status_type               sol_status;
   logic [NUM_AXES-1:0][VEL_W-1:0] sol_vel;

   logic [NUM_AXES-1:0][VEL_W-1:0] last_vel_ff, out_vel, rsp_vel_ff;
   fit_status_type out_status, rsp_status_ff;
   logic           out_held, rsp_held_ff, rsp_valid_ff;

   assign accepted = req_ch.valid && req_ch.ready;

   assign ring_d = (state_ff == ST_IDLE)
      ? '{stamp: req_ch.sample_time,
          pos: {req_ch.pos_z, req_ch.pos_y, req_ch.pos_x}}
      : cell_q[WINDOW-1];

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      wlsv_cell u_cell (
         .clock (clock),
         .shift (shift_en),
         .d     ((i == 0) ? ring_d : cell_q[(i == 0) ? 0 : i - 1]),
         .q     (cell_q[i])
      );
   end

   assign tap       = cell_q[WINDOW-1];
   assign tap_pos   = {1'b0, count_ff} + (N_W+1)'(cyc_ff);
   assign tap_valid = (state_ff == ST_ROTATE) && (tap_pos >= (N_W+1)'(WINDOW));
   assign tap_first = tap_pos == (N_W+1)'(WINDOW);
   assign dt        = tap_first ? '0 : (tap.stamp - t0_ff);

   always_comb begin
      count_in = (count_ff < N_W'(WINDOW)) ? (count_ff + 1'b1) : count_ff;
   end

   always_comb begin
      state_in  = state_ff;
      cyc_in    = cyc_ff;
      shift_en  = 1'b0;
      sol_start = 1'b0;
      load_rsp  = 1'b0;
      req_ch.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               shift_en = 1'b1;
               cyc_in   = '0;
               state_in = (count_in < N_W'(MIN_SAMPLES)) ? ST_OUT : ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            shift_en = 1'b1;
            if (cyc_ff == LOG_W'(WINDOW - 1)) begin
               cyc_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cyc_in = cyc_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (cyc_ff == LOG_W'(2)) begin
               cyc_in    = '0;
               sol_start = 1'b1;
               state_in  = ST_SOLVE;
            end else begin
               cyc_in = cyc_ff + 1'b1;
            end
         end
         ST_SOLVE: begin
            if (sol_status.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cyc_ff       <= '0;
         count_ff     <= '0;
         few_ff       <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         last_vel_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cyc_ff      <= cyc_in;
         s1_valid_ff <= tap_valid;
         s2_valid_ff <= s1_valid_ff;
         if (accepted) begin
            count_ff <= count_in;
            few_ff   <= count_in < N_W'(MIN_SAMPLES);
         end
         if (load_rsp) begin
            last_vel_ff  <= out_vel;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         tp_full[a] = $signed({1'b0, s1_dt_ff}) * $signed(s1_pos_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (tap_first && tap_valid) begin
         t0_ff <= tap.stamp;
      end
      s1_dt_ff  <= dt;
      s1_pos_ff <= tap.pos;
      s2_dt_ff  <= s1_dt_ff;
      s2_pos_ff <= s1_pos_ff;
      s2_tt_ff  <= s1_dt_ff * s1_dt_ff;
      for (int a = 0; a < NUM_AXES; a++) begin
         s2_tp_ff[a] <= tp_full[a][DT_W+POS_W-1:0];
      end
      if (accepted) begin
         sum_t_ff  <= '0;
         sum_tt_ff <= '0;
         sum_p_ff  <= '0;
         sum_tp_ff <= '0;
      end else if (s2_valid_ff) begin
         sum_t_ff  <= sum_t_ff + SX_W'(s2_dt_ff);
         sum_tt_ff <= sum_tt_ff + SXX_W'(s2_tt_ff);
         for (int a = 0; a < NUM_AXES; a++) begin
            sum_p_ff[a]  <= sum_p_ff[a] + SY_W'($signed(s2_pos_ff[a]));
            sum_tp_ff[a] <= sum_tp_ff[a] + SXY_W'($signed(s2_tp_ff[a]));
         end
      end
   end

   wlsv_solve u_solve (
      .clock     (clock),
      .reset     (reset),
      .start     (sol_start),
      .win_count (count_ff),
      .sum_t     (sum_t_ff),
      .sum_tt    (sum_tt_ff),
      .sum_p     (sum_p_ff),
      .sum_tp    (sum_tp_ff),
      .status    (sol_status),
      .vel       (sol_vel)
   );

   always_comb begin
      out_vel    = last_vel_ff;
      out_status = FIT_OK;
      out_held   = 1'b0;
      if (few_ff) begin
         out_status = FIT_FEW;
      end else if (sol_status.den_zero) begin
         out_status = FIT_DEGENERATE;
      end else begin
         out_vel = sol_vel;
         if ((!sol_vel[0][VEL_W-1] && (|sol_vel[0]) && last_vel_ff[0][VEL_W-1]) ||
             (sol_vel[0][VEL_W-1] && !last_vel_ff[0][VEL_W-1] && (|last_vel_ff[0]))) begin
            out_vel[0] = last_vel_ff[0];
            out_held   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_vel_ff    <= out_vel;
         rsp_status_ff <= out_status;
         rsp_held_ff   <= out_held;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.vel_x      = rsp_vel_ff[0];
   assign rsp_ch.vel_y      = rsp_vel_ff[1];
   assign rsp_ch.vel_z      = rsp_vel_ff[2];
   assign rsp_ch.fit_status = rsp_status_ff;
   assign rsp_ch.x_held     = rsp_held_ff;
endmodule

`default_nettype wire
